>>> hw/rtl/ttip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared constants, codes and controller/datapath interface types for the
// track table interpolator.
// ----------------------------------------------------------------------------
package ttip_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int ADDR_W        = $clog2(TABLE_DEPTH);
   localparam int COUNT_W       = ADDR_W + 1;
   localparam int WORD_W        = 32;
   localparam int FRACTION_BITS = 16;
   localparam int DIV_CNT_W     = $clog2(FRACTION_BITS);
   localparam int ENTRY_W       = 3 * WORD_W;

   // Request opcodes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   // Result status codes.
   localparam logic ST_OK    = 1'b0;
   localparam logic ST_EMPTY = 1'b1;

   // Table read address sources.
   typedef enum logic [2:0] {
      ADDR_ZERO,
      ADDR_LAST,
      ADDR_MID,
      ADDR_LO,
      ADDR_HI
   } addr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         cap_query;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         set_empty;
      logic         set_entry;
      logic         init_search;
      logic         upd_search;
      logic         cap_lo;
      logic         cap_hi;
      logic         div_step;
      logic         mul_az;
      logic         mul_el;
      logic         add_az;
      logic         add_el;
      logic         push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;
      logic le_entry;
      logic ge_entry;
      logic search_done;
      logic div_last;
      logic rsp_full;
   } sts_type;

endpackage

>>> hw/rtl/ttip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module ttip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ttip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_ctrl
// Sequencer: end checks, binary search, serial divide, two multiplies and
// result hand-off.
// ----------------------------------------------------------------------------
module ttip_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_opcode,
   output logic              req_stall,
   input  ttip_pkg::sts_type sts,
   output ttip_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_FIRST,
      S_LAST,
      S_SRCH_ISSUE,
      S_SRCH_CMP,
      S_GET_LO,
      S_GET_HI,
      S_DIV,
      S_MUL_AZ,
      S_ADD_AZ,
      S_ADD_EL,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = ttip_pkg::ADDR_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_opcode == ttip_pkg::OP_INTERP)) begin
               cmd.cap_query = 1'b1;
               state_in      = S_START;
            end
         end
         S_START: begin
            if (sts.n_zero) begin
               cmd.set_empty = 1'b1;
               state_in      = S_PUSH;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ttip_pkg::ADDR_ZERO;
               state_in     = S_FIRST;
            end
         end
         S_FIRST: begin
            if (sts.le_entry) begin
               cmd.set_entry = 1'b1;
               state_in      = S_PUSH;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ttip_pkg::ADDR_LAST;
               state_in     = S_LAST;
            end
         end
         S_LAST: begin
            if (sts.ge_entry) begin
               cmd.set_entry = 1'b1;
               state_in      = S_PUSH;
            end else begin
               cmd.init_search = 1'b1;
               state_in        = S_SRCH_ISSUE;
            end
         end
         S_SRCH_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (sts.search_done) begin
               cmd.addr_sel = ttip_pkg::ADDR_LO;
               state_in     = S_GET_LO;
            end else begin
               cmd.addr_sel = ttip_pkg::ADDR_MID;
               state_in     = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.upd_search = 1'b1;
            state_in       = S_SRCH_ISSUE;
         end
         S_GET_LO: begin
            cmd.cap_lo   = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ttip_pkg::ADDR_HI;
            state_in     = S_GET_HI;
         end
         S_GET_HI: begin
            cmd.cap_hi = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_MUL_AZ;
            end
         end
         S_MUL_AZ: begin
            cmd.mul_az = 1'b1;
            state_in   = S_ADD_AZ;
         end
         S_ADD_AZ: begin
            cmd.add_az = 1'b1;
            cmd.mul_el = 1'b1;
            state_in   = S_ADD_EL;
         end
         S_ADD_EL: begin
            cmd.add_el = 1'b1;
            state_in   = S_PUSH;
         end
         S_PUSH: begin
            if (!sts.rsp_full) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      stall_in = (state_in != S_IDLE);
   end

   // State and registered stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

>>> hw/rtl/ttip_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_dp
// Datapath: entry table, search bounds, restoring divider, shared
// multiplier, result and response registers, entry count register.
// ----------------------------------------------------------------------------
module ttip_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [ttip_pkg::ADDR_W-1:0]         req_entry_index,
   input  logic [ttip_pkg::WORD_W-1:0]         req_entry_time,
   input  logic signed [ttip_pkg::WORD_W-1:0]  req_entry_azimuth,
   input  logic signed [ttip_pkg::WORD_W-1:0]  req_entry_elevation,
   input  logic [ttip_pkg::WORD_W-1:0]         req_query_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_azimuth,
   output logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_elevation,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttip_pkg::COUNT_W-1:0]        csr_data,
   input  ttip_pkg::cmd_type                   cmd,
   output ttip_pkg::sts_type                   sts
);

   localparam int AW = ttip_pkg::ADDR_W;
   localparam int WW = ttip_pkg::WORD_W;
   localparam int FB = ttip_pkg::FRACTION_BITS;
   localparam int PW = WW + 1 + FB + 1;

   logic [ttip_pkg::COUNT_W-1:0] count_ff;
   logic [WW-1:0]                query_ff;
   logic [AW-1:0]                lo_ff, hi_ff, mid_ff;
   logic [WW-1:0]                t_lo_ff, den_ff;
   logic signed [WW-1:0]         a_lo_ff, e_lo_ff, a_hi_ff, e_hi_ff;
   logic [WW-1:0]                rem_ff;
   logic [FB-1:0]                frac_ff;
   logic [ttip_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic signed [PW-1:0]         prod_ff;
   logic                         res_status_ff;
   logic signed [WW-1:0]         res_az_ff, res_el_ff;
   logic                         rsp_valid_ff, rsp_status_ff;
   logic signed [WW-1:0]         rsp_az_ff, rsp_el_ff;

   logic                         wr_en;
   logic [AW-1:0]                last_idx, mid_idx, rd_addr;
   logic [ttip_pkg::ENTRY_W-1:0] rd_data;
   logic [WW-1:0]                rd_time;
   logic signed [WW-1:0]         rd_az, rd_el;
   logic [AW:0]                  mid_sum;
   logic [WW:0]                  rem_sh;
   logic signed [WW:0]           diff;
   logic signed [PW-1:0]         prod_in;
   logic signed [WW-1:0]         step;

   // Table write on an accepted load request.
   assign wr_en = req_valid && !req_stall && (req_opcode == ttip_pkg::OP_LOAD);

   // Clamp the entry count to the table depth; last index follows.
   always_comb begin
      if (count_ff >= ttip_pkg::COUNT_W'(ttip_pkg::TABLE_DEPTH)) begin
         last_idx = AW'(ttip_pkg::TABLE_DEPTH - 1);
      end else begin
         last_idx = AW'(count_ff - ttip_pkg::COUNT_W'(1));
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_idx = mid_sum[AW:1];

   // Read address selection.
   always_comb begin
      case (cmd.addr_sel)
         ttip_pkg::ADDR_ZERO: rd_addr = '0;
         ttip_pkg::ADDR_LAST: rd_addr = last_idx;
         ttip_pkg::ADDR_MID:  rd_addr = mid_idx;
         ttip_pkg::ADDR_LO:   rd_addr = lo_ff;
         ttip_pkg::ADDR_HI:   rd_addr = hi_ff;
         default:             rd_addr = '0;
      endcase
   end

   ttip_ram #(
      .WIDTH (ttip_pkg::ENTRY_W),
      .DEPTH (ttip_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data ({req_entry_time, req_entry_azimuth, req_entry_elevation}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time = rd_data[3*WW-1:2*WW];
   assign rd_az   = rd_data[2*WW-1:WW];
   assign rd_el   = rd_data[WW-1:0];

   // Divider shift and multiplier operand.
   assign rem_sh = {rem_ff, 1'b0};
   always_comb begin
      if (cmd.mul_el) begin
         diff = {e_hi_ff[WW-1], e_hi_ff} - {e_lo_ff[WW-1], e_lo_ff};
      end else begin
         diff = {a_hi_ff[WW-1], a_hi_ff} - {a_lo_ff[WW-1], a_lo_ff};
      end
      prod_in = diff * $signed({1'b0, frac_ff});
   end

   // Floored step: arithmetic shift drops the fraction bits.
   assign step = prod_ff[FB+WW-1:FB];

   // Status to the controller.
   always_comb begin
      sts.n_zero      = (count_ff == '0);
      sts.le_entry    = (query_ff <= rd_time);
      sts.ge_entry    = (query_ff >= rd_time);
      sts.search_done = ({1'b0, hi_ff} <= ({1'b0, lo_ff} + (AW+1)'(1)));
      sts.div_last    = (div_cnt_ff == ttip_pkg::DIV_CNT_W'(FB - 1));
      sts.rsp_full    = rsp_valid_ff;
   end

   // Control registers: entry count and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.cap_query) begin
         query_ff <= req_query_time;
      end
      if (cmd.init_search) begin
         lo_ff <= '0;
         hi_ff <= last_idx;
      end
      if (cmd.rd_en && (cmd.addr_sel == ttip_pkg::ADDR_MID)) begin
         mid_ff <= mid_idx;
      end
      if (cmd.upd_search) begin
         if (rd_time <= query_ff) begin
            lo_ff <= mid_ff;
         end else begin
            hi_ff <= mid_ff;
         end
      end
      if (cmd.cap_lo) begin
         t_lo_ff <= rd_time;
         a_lo_ff <= rd_az;
         e_lo_ff <= rd_el;
      end
      if (cmd.cap_hi) begin
         a_hi_ff    <= rd_az;
         e_hi_ff    <= rd_el;
         den_ff     <= rd_time - t_lo_ff;
         rem_ff     <= query_ff - t_lo_ff;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + ttip_pkg::DIV_CNT_W'(1);
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff  <= WW'(rem_sh - {1'b0, den_ff});
            frac_ff <= {frac_ff[FB-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[WW-1:0];
            frac_ff <= {frac_ff[FB-2:0], 1'b0};
         end
      end
      if (cmd.mul_az || cmd.mul_el) begin
         prod_ff <= prod_in;
      end
      // Result registers.
      if (cmd.set_empty) begin
         res_status_ff <= ttip_pkg::ST_EMPTY;
         res_az_ff     <= '0;
         res_el_ff     <= '0;
      end
      if (cmd.set_entry) begin
         res_status_ff <= ttip_pkg::ST_OK;
         res_az_ff     <= rd_az;
         res_el_ff     <= rd_el;
      end
      if (cmd.add_az) begin
         res_status_ff <= ttip_pkg::ST_OK;
         res_az_ff     <= a_lo_ff + step;
      end
      if (cmd.add_el) begin
         res_el_ff <= e_lo_ff + step;
      end
      // Response payload.
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_az_ff     <= res_az_ff;
         rsp_el_ff     <= res_el_ff;
      end
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_interp_azimuth   = rsp_az_ff;
   assign rsp_interp_elevation = rsp_el_ff;

endmodule

>>> hw/rtl/track_table_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_table_interpolator_top
// Piecewise-linear interpolation over a time-sorted table of azimuth and
// elevation samples.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Carries
//  req     | req_valid/stall    | opcode, entry index/time/angles, query time
//  rsp     | rsp_valid/stall    | status, interpolated azimuth and elevation
//  csr     | csr_valid/ready    | entry count
//
// A load is written to the table as it is accepted, and the next request can
// follow it directly. A query runs a binary search over the entry bounds and
// a restoring divide, then two multiplies on one multiplier; the next request
// is taken once the response has been pushed.
// Reset is synchronous and clears the controller, the entry count and the
// response valid; table contents are undefined until loaded.
// A stalled response holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module track_table_interpolator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [ttip_pkg::ADDR_W-1:0]         req_entry_index,
   input  logic [ttip_pkg::WORD_W-1:0]         req_entry_time,
   input  logic signed [ttip_pkg::WORD_W-1:0]  req_entry_azimuth,
   input  logic signed [ttip_pkg::WORD_W-1:0]  req_entry_elevation,
   input  logic [ttip_pkg::WORD_W-1:0]         req_query_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_azimuth,
   output logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_elevation,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttip_pkg::COUNT_W-1:0]        csr_data
);

   ttip_pkg::cmd_type cmd;
   ttip_pkg::sts_type sts;

   // Sequencer.
   ttip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   ttip_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_entry_index      (req_entry_index),
      .req_entry_time       (req_entry_time),
      .req_entry_azimuth    (req_entry_azimuth),
      .req_entry_elevation  (req_entry_elevation),
      .req_query_time       (req_query_time),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_interp_azimuth   (rsp_interp_azimuth),
      .rsp_interp_elevation (rsp_interp_elevation),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .sts                  (sts)
   );

endmodule

>>> hw/rtl/ttip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_checker
// Port-level checks of the track table interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module ttip_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_status,
   input logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_azimuth,
   input logic signed [ttip_pkg::WORD_W-1:0]  rsp_interp_elevation
);

   // A stalled response keeps its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_interp_azimuth) && $stable(rsp_interp_elevation))
      else $error("stalled response changed");

   // An empty-table answer carries zero angles.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ttip_pkg::ST_EMPTY) |->
      (rsp_interp_azimuth == '0) && (rsp_interp_elevation == '0))
      else $error("empty status with nonzero angles");

   // No response and no request stall right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("activity right after reset");

   // An accepted query holds off the next request.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == ttip_pkg::OP_INTERP) |=> req_stall)
      else $error("query accepted without going busy");

endmodule

bind track_table_interpolator_top ttip_checker u_ttip_checker (.*);

>>> dv/track_table_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_table_interpolator_top_tb
// Self-checking bench for the track table interpolator. Table loads and
// interpolation queries are driven through the request channel. An internal
// predictor keeps its own table and entry count and queues the expected
// response of every accepted query. Responses are compared in order. The
// entry count is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module track_table_interpolator_top_tb;

   typedef struct {
      logic        opcode;
      logic [11:0] index;
      logic [31:0] etime;
      logic [31:0] az;
      logic [31:0] el;
      logic [31:0] qtime;
   } request_type;

   typedef struct {
      logic        status;
      logic [31:0] az;
      logic [31:0] el;
   } answer_type;

   // Scoreboard: mirrors the table and queues expected answers.
   class interp_scoreboard;
      logic [31:0] time_tab[ttip_pkg::TABLE_DEPTH];
      logic [31:0] az_tab[ttip_pkg::TABLE_DEPTH];
      logic [31:0] el_tab[ttip_pkg::TABLE_DEPTH];
      int unsigned entry_count;
      answer_type  pending[$];
      int          mismatches;
      int          answers_checked;
      int          empty_answers;

      function void set_count(logic [12:0] value);
         entry_count = value;
      endfunction

      // Lower angle plus the floored fraction of the angle difference.
      function logic [31:0] blend(logic [31:0] a_lo, logic [31:0] a_hi,
                                  longint frac);
         longint lo_val;
         longint diff;
         longint step;
         lo_val = longint'($signed(a_lo));
         diff = longint'($signed(a_hi)) - lo_val;
         step = (diff * frac) >>> ttip_pkg::FRACTION_BITS;
         return 32'(lo_val + step);
      endfunction

      function answer_type interpolate(logic [31:0] q);
         answer_type  ans;
         int unsigned n;
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         logic [63:0] num;
         logic [63:0] frac;
         n = (entry_count > ttip_pkg::TABLE_DEPTH) ? ttip_pkg::TABLE_DEPTH : entry_count;
         ans.status = ttip_pkg::ST_OK;
         if (n == 0) begin
            ans.status = ttip_pkg::ST_EMPTY;
            ans.az = '0;
            ans.el = '0;
            return ans;
         end
         if (q <= time_tab[0]) begin
            ans.az = az_tab[0];
            ans.el = el_tab[0];
            return ans;
         end
         if (q >= time_tab[n-1]) begin
            ans.az = az_tab[n-1];
            ans.el = el_tab[n-1];
            return ans;
         end
         lo = 0;
         hi = n - 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (time_tab[mid] <= q) lo = mid;
            else hi = mid;
         end
         if (time_tab[hi] <= time_tab[lo]) begin
            ans.az = az_tab[lo];
            ans.el = el_tab[lo];
            return ans;
         end
         num = {32'd0, 32'(q - time_tab[lo])} << ttip_pkg::FRACTION_BITS;
         frac = num / {32'd0, 32'(time_tab[hi] - time_tab[lo])};
         ans.az = blend(az_tab[lo], az_tab[hi], longint'(frac));
         ans.el = blend(el_tab[lo], el_tab[hi], longint'(frac));
         return ans;
      endfunction

      // Called for every accepted request.
      function void note_request(request_type r);
         if (r.opcode == ttip_pkg::OP_LOAD) begin
            time_tab[r.index] = r.etime;
            az_tab[r.index] = r.az;
            el_tab[r.index] = r.el;
         end else begin
            pending.push_back(interpolate(r.qtime));
         end
      endfunction

      function void report(string what, answer_type exp_a, answer_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected status %0d az %h el %h, got status %0d az %h el %h",
                     what, exp_a.status, exp_a.az, exp_a.el, got.status, got.az, got.el);
      endfunction

      // Called for every accepted response.
      function void check_answer(answer_type got);
         answer_type exp_a;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: response with nothing outstanding (az %h el %h)",
                        got.az, got.el);
            return;
         end
         exp_a = pending.pop_front();
         answers_checked++;
         if (exp_a.status == ttip_pkg::ST_EMPTY) empty_answers++;
         if (got.status !== exp_a.status) report("status", exp_a, got);
         else if (got.az !== exp_a.az) report("azimuth", exp_a, got);
         else if (got.el !== exp_a.el) report("elevation", exp_a, got);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [ttip_pkg::ADDR_W-1:0] req_entry_index;
   logic [ttip_pkg::WORD_W-1:0] req_entry_time;
   logic signed [ttip_pkg::WORD_W-1:0] req_entry_azimuth;
   logic signed [ttip_pkg::WORD_W-1:0] req_entry_elevation;
   logic [ttip_pkg::WORD_W-1:0] req_query_time;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic signed [ttip_pkg::WORD_W-1:0] rsp_interp_azimuth;
   logic signed [ttip_pkg::WORD_W-1:0] rsp_interp_elevation;
   logic        csr_valid;
   logic        csr_ready;
   logic [ttip_pkg::COUNT_W-1:0] csr_data;

   interp_scoreboard sb;
   bit          loaded[ttip_pkg::TABLE_DEPTH];
   int          burst_left;
   int          hold_off_request;
   int          load_count;
   int          query_count;
   int          phase_count;

   track_table_interpolator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_entry_index(req_entry_index),
      .req_entry_time(req_entry_time), .req_entry_azimuth(req_entry_azimuth),
      .req_entry_elevation(req_entry_elevation), .req_query_time(req_query_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_interp_azimuth(rsp_interp_azimuth),
      .rsp_interp_elevation(rsp_interp_elevation),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Offer one request and hold it until accepted; valid stays high afterwards.
   task automatic send_request(request_type r);
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_entry_index <= r.index;
      req_entry_time <= r.etime;
      req_entry_azimuth <= r.az;
      req_entry_elevation <= r.el;
      req_query_time <= r.qtime;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.opcode == ttip_pkg::OP_LOAD) begin
         load_count++;
         loaded[r.index] = 1'b1;
      end else begin
         query_count++;
      end
   endtask

   // Bursty sender: after each burst drop valid for a random gap.
   task automatic issue(request_type r);
      int gap;
      send_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic load_entry(int idx, logic [31:0] t, logic [31:0] az, logic [31:0] el);
      request_type r;
      r.opcode = ttip_pkg::OP_LOAD;
      r.index = 12'(idx);
      r.etime = t;
      r.az = az;
      r.el = el;
      r.qtime = $urandom();
      issue(r);
   endtask

   task automatic query(logic [31:0] q);
      request_type r;
      r.opcode = ttip_pkg::OP_INTERP;
      r.index = $urandom();
      r.etime = $urandom();
      r.az = $urandom();
      r.el = $urandom();
      r.qtime = q;
      issue(r);
   endtask

   // Stop sending until every outstanding response has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Count register write; the block is idle by then.
   task automatic write_count(int value);
      drain();
      repeat (80) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= ttip_pkg::COUNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_count(ttip_pkg::COUNT_W'(value));
      phase_count++;
   endtask

   // Query times near the loaded samples, between them, or anywhere.
   function automatic logic [31:0] pick_query(int n);
      int i;
      i = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return sb.time_tab[i];
         2: return sb.time_tab[i] + $urandom_range(1, 3);
         3: return sb.time_tab[i] - $urandom_range(1, 3);
         4: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
         default: return sb.time_tab[i] + ($urandom() % 32'h0010_0000);
      endcase
   endfunction

   // Fill entries 0..n-1 (only the unloaded ones if only_missing) with sorted random times and random angles.
   task automatic load_sorted_table(int n, bit only_missing);
      logic [31:0] times[$];
      logic [31:0] base;
      logic [31:0] span;
      base = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(0);
      span = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF - base : ($urandom() >> 8) + 32'(n);
      times.delete();
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 15) == 0) times.push_back(times[i-1]);
         else times.push_back(base + ($urandom() % span));
      end
      times.sort();
      for (int i = 0; i < n; i++)
         if (!only_missing || !loaded[i])
            load_entry(i, times[i], $urandom(), $urandom());
   endtask

   // Receiver: stalls on its own changing pattern and checks every response.
   initial begin
      int mode;
      int mode_left;
      answer_type got;
      mode = 0;
      mode_left = 100;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.az = rsp_interp_azimuth;
            got.el = rsp_interp_elevation;
            sb.check_answer(got);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (hold_off_request > 0) begin
            hold_off_request--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Safety net against a hung handshake.
   initial begin
      #20ms;
      $display("track_table_interpolator_top test failed");
      $finish;
   end

   // Stimulus.
   initial begin
      int n;
      int n_eff;
      int items;
      bit ends_only;
      logic [31:0] t_end;
      sb = new();
      burst_left = 0;
      hold_off_request = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= ttip_pkg::OP_LOAD;
      req_entry_index <= '0;
      req_entry_time <= '0;
      req_entry_azimuth <= '0;
      req_entry_elevation <= '0;
      req_query_time <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme fields, equal times, single entry.
      query(32'h0);
      query(32'hFFFF_FFFF);
      load_entry(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      load_entry(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      load_entry(4095, 32'h0, 32'h0, 32'hFFFF_FFFF);
      query(32'h1234_5678);
      write_count(2);
      query(32'h0);
      query(32'h0001_0000);
      query(32'hFFFF_FFFF);
      query(32'h8000_0000);
      query(32'h0001_0001);
      query(32'hFFFF_FFFE);
      write_count(1);
      query(32'h5);
      query(32'hFFFF_FFFF);
      load_entry(1, 32'h0001_0000, 32'h1, 32'hFFFF_FFFF);
      write_count(2);
      query(32'h0001_0000);
      query(32'h0);

      // Random phases with the count moving across its range.
      while (load_count + query_count < 1550) begin
         case ($urandom_range(0, 19))
            0: n = 0;
            1: n = ttip_pkg::TABLE_DEPTH;
            2: n = $urandom_range(ttip_pkg::TABLE_DEPTH + 1, 8191);
            3: n = $urandom_range(65, 200);
            default: n = $urandom_range(1, 20);
         endcase
         if (phase_count == 8) n = ttip_pkg::TABLE_DEPTH;
         if (phase_count == 12) n = 8191;
         n_eff = (n > ttip_pkg::TABLE_DEPTH) ? ttip_pkg::TABLE_DEPTH : n;
         ends_only = (n_eff == ttip_pkg::TABLE_DEPTH);
         write_count(n);
         if (ends_only) begin
            // Equal first and last times keep every full-depth query at an end.
            t_end = $urandom();
            load_entry(0, t_end, $urandom(), $urandom());
            load_entry(ttip_pkg::TABLE_DEPTH - 1, t_end, $urandom(), $urandom());
         end else if (n_eff > 0) begin
            load_sorted_table(n_eff, n_eff > 64);
         end
         if ($urandom_range(0, 4) == 0) hold_off_request = $urandom_range(300, 600);
         items = $urandom_range(30, 90);
         for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 9) < 2) begin
               if (n_eff > 0 && !ends_only && $urandom_range(0, 2) != 0)
                  load_entry($urandom_range(0, n_eff - 1), $urandom(), $urandom(), $urandom());
               else if (ends_only)
                  load_entry($urandom_range(1, ttip_pkg::TABLE_DEPTH - 2), $urandom(),
                             $urandom(), $urandom());
               else if ($urandom_range(0, 1) == 0)
                  load_entry($urandom_range(0, ttip_pkg::TABLE_DEPTH - 1), $urandom(),
                             $urandom(), $urandom());
            end else if (ends_only) begin
               query(pick_query(1));
            end else begin
               query((n_eff > 0) ? pick_query(n_eff) : $urandom());
            end
         end
         if ($urandom_range(0, 3) == 0) drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.mismatches++;
         $display("%0d responses never arrived", sb.pending.size());
      end
      $display("Covered %0d loads and %0d queries (%0d empty-table) over %0d count settings.",
               load_count, query_count, sb.empty_answers, phase_count);
      $display("Checked %0d responses, %0d mismatches.", sb.answers_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("track_table_interpolator_top test passed");
      end else begin
         $display("track_table_interpolator_top test failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ttip_pkg.sv
hw/rtl/ttip_ram.sv
hw/rtl/ttip_ctrl.sv
hw/rtl/ttip_dp.sv
hw/rtl/track_table_interpolator_top.sv
hw/rtl/ttip_checker.sv
dv/track_table_interpolator_top_tb.sv
